// ----- rtl/rvss_pkg.sv -----
package rvss_pkg;

   localparam int MEM_BYTES_DEF = 4096;

   typedef enum logic [1:0] {
      CMD_WRITE_MEM = 2'd0,
      CMD_STEP      = 2'd1,
      CMD_READ_REG  = 2'd2,
      CMD_READ_MEM  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      HALT_NONE    = 2'd0,
      HALT_ZERO    = 2'd1,
      HALT_UNKNOWN = 2'd2
   } halt_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_FETCH,
      ST_FETCH_WAIT,
      ST_DECODE,
      ST_EXEC,
      ST_MEM,
      ST_MEM_WAIT,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      cmd_type     command;
      logic [9:0]  word_index;
      logic [31:0] word_data;
      logic [4:0]  reg_index;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [11:0] pc_before;
      logic [31:0] insn_word;
      logic        dest_written;
      logic [4:0]  dest_number;
      logic [31:0] dest_value;
      logic        store_done;
      logic [11:0] pc_after;
      logic        halted_now;
      logic [1:0]  halt_cause;
   } rsp_type;

   // controller commands to the datapath
   typedef struct packed {
      logic clear_step;   // write one zero word during the clear pass
      logic latch_req;    // capture the request
      logic fetch_addr;   // present fetch address to memory
      logic fetch_latch;  // capture instruction word, read registers
      logic exec;         // compute result, address, next pc
      logic mem_access;   // issue load or store / memory read or write
      logic mem_latch;    // capture load data
      logic commit;       // update regs, pc, halt, build response
   } ctl_type;

   typedef struct packed {
      logic clear_last;
      logic is_mem_op;    // load, store or memory command needs memory
   } sts_type;

endpackage

// ----- rtl/rvss_ram.sv -----
module rvss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rvss_datapath.sv -----
module rvss_datapath
   import rvss_pkg::*;
#(
   parameter int MEM_BYTES = MEM_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_payload,
   input  ctl_type ctl,
   output sts_type sts,
   output rsp_type rsp_payload
);

   localparam int AW = $clog2(MEM_BYTES);
   localparam int WAW = AW - 2;   // address bits of one byte lane

   // architectural state
   logic [AW-1:0] pc_ff, pc_in;
   logic          halt_ff, halt_in;
   halt_type      cause_ff, cause_in;
   logic [WAW-1:0] clr_cnt_ff, clr_cnt_in;

   req_type       req_ff;
   logic [31:0]   insn_ff, a_ff, b_ff, val_ff, load_ff;
   logic [31:0]   next_ff, addr_ff;
   logic          wr_ff, st_ff, halt_hit_ff, ld_ff;
   rsp_type       rsp_ff;

   // memory: four byte lanes so an unaligned word is one access
   logic [AW-1:0]  mem_addr;
   logic [31:0]    mem_wdata;
   logic           mem_we;
   logic [1:0]     lane_off;
   logic [1:0]     rot_ff;
   logic [WAW-1:0] lane_addr [4];
   logic [7:0]     lane_wdata [4];
   logic [7:0]     lane_rdata [4];
   logic [31:0]    mem_word;

   // register file: two read ports from two copies
   logic [4:0]  rf_ra, rf_rb, rf_wa;
   logic [31:0] rf_wd, rf_qa, rf_qb;
   logic        rf_we;

   assign lane_off = mem_addr[1:0];

   // lane l holds byte address with low bits l; byte i sits in lane (off+i)
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         logic [1:0]  i;
         logic [AW:0] ba;
         i  = 2'(l) - lane_off;
         ba = {1'b0, mem_addr} + {{(AW-1){1'b0}}, i};
         lane_addr[l]  = ba[AW-1:2];
         lane_wdata[l] = mem_wdata[8*i +: 8];
      end
      if (ctl.clear_step) begin
         for (int l = 0; l < 4; l++) begin
            lane_addr[l]  = clr_cnt_ff;
            lane_wdata[l] = 8'h00;
         end
      end
   end

   for (genvar l = 0; l < 4; l++) begin : g_lane
      rvss_ram #(.WIDTH(8), .DEPTH(MEM_BYTES / 4)) u_lane (
         .clock   (clock),
         .wr_en   (mem_we | ctl.clear_step),
         .wr_addr (lane_addr[l]),
         .wr_data (lane_wdata[l]),
         .rd_addr (lane_addr[l]),
         .rd_data (lane_rdata[l])
      );
   end

   // reassemble the word from lanes using the offset of the access
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mem_word[8*i +: 8] = lane_rdata[2'(i) + rot_ff];
      end
   end

   rvss_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
      .clock(clock), .wr_en(rf_we), .wr_addr(rf_wa), .wr_data(rf_wd),
      .rd_addr(rf_ra), .rd_data(rf_qa));
   rvss_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
      .clock(clock), .wr_en(rf_we), .wr_addr(rf_wa), .wr_data(rf_wd),
      .rd_addr(rf_rb), .rd_data(rf_qb));

   // immediates and decode of the latched instruction
   logic [31:0] imm_i, imm_s, imm_b, imm_j;
   logic        op_add, op_sub, op_addi, op_lw, op_sw, op_beq, op_jal, op_jalr, op_lui;
   assign imm_i = {{20{insn_ff[31]}}, insn_ff[31:20]};
   assign imm_s = {{20{insn_ff[31]}}, insn_ff[31:25], insn_ff[11:7]};
   assign imm_b = {{19{insn_ff[31]}}, insn_ff[31], insn_ff[7], insn_ff[30:25],
                   insn_ff[11:8], 1'b0};
   assign imm_j = {{11{insn_ff[31]}}, insn_ff[31], insn_ff[19:12], insn_ff[20],
                   insn_ff[30:21], 1'b0};
   assign op_add  = (insn_ff & 32'hFE00707F) == 32'h00000033;
   assign op_sub  = (insn_ff & 32'hFE00707F) == 32'h40000033;
   assign op_addi = (insn_ff & 32'h0000707F) == 32'h00000013;
   assign op_lw   = (insn_ff & 32'h0000707F) == 32'h00002003;
   assign op_sw   = (insn_ff & 32'h0000707F) == 32'h00002023;
   assign op_beq  = (insn_ff & 32'h0000707F) == 32'h00000063;
   assign op_jal  = (insn_ff & 32'h0000007F) == 32'h0000006F;
   assign op_jalr = (insn_ff & 32'h0000707F) == 32'h00000067;
   assign op_lui  = (insn_ff & 32'h0000007F) == 32'h00000037;

   logic [31:0] pc_ext, pc4;
   assign pc_ext = {{(32-AW){1'b0}}, pc_ff};
   assign pc4    = pc_ext + 32'd4;

   logic [AW-1:0] widx_addr;
   assign widx_addr = AW'({req_ff.word_index, 2'b00});

   // memory and register file port steering
   always_comb begin
      mem_addr  = pc_ff;
      mem_wdata = req_ff.word_data;
      mem_we    = 1'b0;
      if (ctl.mem_access) begin
         if (req_ff.command == CMD_STEP) begin
            mem_addr  = addr_ff[AW-1:0];
            mem_wdata = b_ff;
            mem_we    = st_ff;
         end else begin
            mem_addr = widx_addr;
            mem_we   = (req_ff.command == CMD_WRITE_MEM);
         end
      end
      rf_ra = ctl.fetch_latch ? mem_word[19:15] : req_ff.reg_index;
      rf_rb = mem_word[24:20];
      rf_wa = insn_ff[11:7];
      rf_wd = val_ff;
      rf_we = ctl.commit && req_ff.command == CMD_STEP && !halt_ff && !halt_hit_ff
              && wr_ff && insn_ff[11:7] != 5'd0;
      // clear pass also zeroes the register file
      if (ctl.clear_step) begin
         rf_wa = clr_cnt_ff[4:0];
         rf_wd = 32'd0;
         rf_we = 1'b1;
      end
   end

   assign sts.clear_last = (clr_cnt_ff == {WAW{1'b1}});
   assign sts.is_mem_op  = (req_ff.command == CMD_STEP) ? (ld_ff | st_ff)
                         : (req_ff.command != CMD_READ_REG);

   // next-state of the datapath registers
   always_comb begin
      pc_in      = pc_ff;
      halt_in    = halt_ff;
      cause_in   = cause_ff;
      clr_cnt_in = ctl.clear_step ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      if (ctl.commit && req_ff.command == CMD_STEP && !halt_ff) begin
         if (halt_hit_ff) begin
            halt_in  = 1'b1;
            cause_in = (insn_ff == 32'd0) ? HALT_ZERO : HALT_UNKNOWN;
         end else begin
            pc_in = next_ff[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= '0;
         halt_ff    <= 1'b0;
         cause_ff   <= HALT_NONE;
         clr_cnt_ff <= '0;
      end else begin
         pc_ff      <= pc_in;
         halt_ff    <= halt_in;
         cause_ff   <= cause_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // payload pipeline registers
   always_ff @(posedge clock) begin
      if (ctl.latch_req) begin
         req_ff <= req_payload;
      end
      if (ctl.fetch_addr || ctl.mem_access) begin
         rot_ff <= lane_off;
      end
      if (ctl.fetch_latch) begin
         insn_ff <= (req_ff.command == CMD_STEP && !halt_ff) ? mem_word : 32'd0;
      end
      if (ctl.exec) begin
         a_ff <= (insn_ff[19:15] == 5'd0) ? 32'd0 : rf_qa;
         b_ff <= (insn_ff[24:20] == 5'd0) ? 32'd0 : rf_qb;
      end
      if (ctl.mem_latch) begin
         load_ff <= mem_word;
      end
   end

   // execute: operands are in a_ff/b_ff in the cycle after exec
   logic exec2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         exec2_ff <= 1'b0;
      end else begin
         exec2_ff <= ctl.exec;
      end
   end

   // next pc and destination value of the decoded instruction
   logic [31:0] next_in, val_in;
   always_comb begin
      next_in = pc4;
      if (op_beq && a_ff == b_ff) next_in = pc_ext + imm_b;
      if (op_jal)  next_in = pc_ext + imm_j;
      if (op_jalr) next_in = (a_ff + imm_i) & 32'hFFFFFFFE;
      val_in = 32'd0;
      if (op_add)           val_in = a_ff + b_ff;
      if (op_sub)           val_in = a_ff - b_ff;
      if (op_addi)          val_in = a_ff + imm_i;
      if (op_jal | op_jalr) val_in = pc4;
      if (op_lui)           val_in = insn_ff & 32'hFFFFF000;
   end

   always_ff @(posedge clock) begin
      if (exec2_ff) begin
         wr_ff       <= op_add | op_sub | op_addi | op_lw | op_jal | op_jalr | op_lui;
         st_ff       <= op_sw && req_ff.command == CMD_STEP && !halt_ff;
         ld_ff       <= op_lw;
         halt_hit_ff <= !(op_add | op_sub | op_addi | op_lw | op_sw | op_beq
                          | op_jal | op_jalr | op_lui);
         addr_ff     <= a_ff + (op_sw ? imm_s : imm_i);
         next_ff     <= next_in;
         val_ff      <= val_in;
      end else if (ctl.mem_latch && ld_ff) begin
         val_ff <= mem_word;
      end
   end

   // response build
   rsp_type rsp_in;
   always_comb begin
      rsp_in            = '0;
      rsp_in.pc_before  = 12'(pc_ff);
      rsp_in.pc_after   = 12'(pc_in);
      rsp_in.halted_now = halt_in;
      rsp_in.halt_cause = cause_in;
      case (req_ff.command)
         CMD_READ_REG: rsp_in.read_data = (req_ff.reg_index == 5'd0) ? 32'd0 : rf_qa;
         CMD_READ_MEM: rsp_in.read_data = load_ff;
         CMD_STEP: begin
            if (!halt_ff) begin
               rsp_in.insn_word  = insn_ff;
               rsp_in.store_done = st_ff && !halt_hit_ff;
               if (rf_we) begin
                  rsp_in.dest_written = 1'b1;
                  rsp_in.dest_number  = insn_ff[11:7];
                  rsp_in.dest_value   = val_ff;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/rvss_ctrl.sv -----
module rvss_ctrl
   import rvss_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output ctl_type ctl,
   output logic    busy,
   output logic    rsp_valid
);

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // sequence: fetch (also reads reg for read command), decode, exec, memory, commit
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      valid_in = 1'b0;
      busy     = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            ctl.clear_step = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            busy = 1'b0;
            ctl.latch_req = start;
            if (start) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            ctl.fetch_addr = 1'b1;
            state_in = ST_FETCH_WAIT;
         end
         ST_FETCH_WAIT: begin
            ctl.fetch_latch = 1'b1;
            state_in = ST_DECODE;
         end
         ST_DECODE: begin
            ctl.exec = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_MEM;
         end
         ST_MEM: begin
            if (sts.is_mem_op) begin
               ctl.mem_access = 1'b1;
               state_in = ST_MEM_WAIT;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_MEM_WAIT: begin
            ctl.mem_latch = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            ctl.commit = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = valid_ff;

endmodule

// ----- rtl/rv32i_subset_core_step_unit.sv -----
// Small RV32I-subset core that runs one command per transaction: memory word
// write, single instruction step, register read or memory word read. After
// reset the byte memory and the register file are cleared by a pass over every
// memory word with busy high. The sequencer walks fetch, register read,
// execute, memory access and commit over registered-read memories; only a
// command that touches memory (memory write, memory read, lw or sw) takes the
// memory access step. The response is on rsp_payload for one cycle while
// rsp_valid is high; the receiver cannot stall it, so it must be captured in
// that cycle. busy stays high until the response is shown and drops in that
// same cycle, so the next transaction can start there.
module rv32i_subset_core_step_unit
   import rvss_pkg::*;
#(
   parameter int MEM_BYTES = MEM_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   ctl_type ctl;
   sts_type sts;

   rvss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .ctl       (ctl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   rvss_datapath #(.MEM_BYTES(MEM_BYTES)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctl         (ctl),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

endmodule
